// ----- hdl/lpmt_pkg.sv -----
// Shared types, codes and helpers for the longest prefix match table.
`default_nettype none
package lpmt_pkg;

  localparam int ADDR_W = 64;
  localparam int LEN_W  = 7;
  localparam int HOP_W  = 8;
  localparam int CNT_OUT_W = 7;
  localparam logic [LEN_W-1:0] MAX_PREFIX_BITS = 7'd64;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_RESOLVE = 2'd2,
    KIND_COUNT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEN   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Item as it travels down the row of route cells
  typedef struct packed {
    logic                 vld;
    kind_t                kind;
    logic [ADDR_W-1:0]    addr;
    logic [LEN_W-1:0]     len;
    logic [HOP_W-1:0]     hop;
    logic                 done;
    status_t              status;
    logic [LEN_W-1:0]     win_len;
    logic [HOP_W-1:0]     best_hop;
    logic [CNT_OUT_W-1:0] count;
    logic                 appended;
  } tok_t;

  // Mask of the top len bits of an address
  function automatic logic [ADDR_W-1:0] top_mask(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] sh;
    sh = MAX_PREFIX_BITS - len;
    if (len >= MAX_PREFIX_BITS) begin
      return {ADDR_W{1'b1}};
    end
    return {ADDR_W{1'b1}} << sh;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/lpmt_cell.sv -----
// One route slot of the table and the stage that hands the item to the next slot.
`default_nettype none
module lpmt_cell import lpmt_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CNT_W-1:0] slots_used,
  input  wire tok_t             tok_in,
  output tok_t                  tok_out
);

  logic [ADDR_W-1:0] prefix;
  logic [LEN_W-1:0]  length;
  logic [HOP_W-1:0]  hop;
  logic              valid;

  logic [ADDR_W-1:0] prefix_next;
  logic [LEN_W-1:0]  length_next;
  logic [HOP_W-1:0]  hop_next;
  logic              valid_next;
  tok_t              tok_next;

  logic exact_hit;
  logic prefix_hit;
  logic my_slot;

  assign exact_hit  = valid && (prefix == tok_in.addr) && (length == tok_in.len);
  assign prefix_hit = valid && (length != '0) &&
                      (((tok_in.addr ^ prefix) & top_mask(length)) == '0);
  assign my_slot    = (slots_used == CNT_W'(INDEX));

  always_comb begin
    tok_next    = tok_in;
    prefix_next = prefix;
    length_next = length;
    hop_next    = hop;
    valid_next  = valid;
    if (tok_in.vld) begin
      unique case (tok_in.kind)
        KIND_ADD: begin
          if (!tok_in.done) begin
            if (exact_hit) begin
              hop_next      = tok_in.hop;
              tok_next.done = 1'b1;
            end else if (my_slot) begin
              prefix_next       = tok_in.addr;
              length_next       = tok_in.len;
              hop_next          = tok_in.hop;
              valid_next        = 1'b1;
              tok_next.done     = 1'b1;
              tok_next.appended = 1'b1;
            end
          end
        end
        KIND_REMOVE: begin
          if (!tok_in.done && exact_hit) begin
            valid_next      = 1'b0;
            tok_next.done   = 1'b1;
            tok_next.status = ST_OK;
          end
        end
        KIND_RESOLVE: begin
          // strict compare keeps the lowest slot on a tie
          if (prefix_hit && (length > tok_in.win_len)) begin
            tok_next.win_len  = length;
            tok_next.best_hop = hop;
          end
        end
        KIND_COUNT: begin
          tok_next.count = tok_in.count + CNT_OUT_W'(valid);
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prefix <= prefix_next;
    length <= length_next;
    hop    <= hop_next;
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= '0;
    end else begin
      valid   <= valid_next;
      tok_out <= tok_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/longest_prefix_match_table_unit.sv -----
// Top level of the longest prefix match route table: a row of route cells.
// An accepted item enters the head register, walks the route cells one cell per
// cycle, waits as a finished result, then moves to the output register. Throughput:
// one item at a time; a new one is taken once the last result is in that register.
// Reset: synchronous; clears all route valid bits, the slot counter and the
// handshake state at once, with no clearing pass.
`default_nettype none
module longest_prefix_match_table_unit import lpmt_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           kind,
  input  wire logic [ADDR_W-1:0]    address,
  input  wire logic [LEN_W-1:0]     route_len,
  input  wire logic [HOP_W-1:0]     route_hop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                status,
  output logic [HOP_W-1:0]          hop_out,
  output logic [CNT_OUT_W-1:0]      valid_count
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // tok[i] feeds cell i; tok[TABLE_DEPTH] leaves the last cell
  tok_t tok [TABLE_DEPTH+1];

  logic             busy;
  logic [CNT_W-1:0] slots_used;

  // finished result waiting for the output register
  logic                 fin_valid;
  status_t              fin_status;
  logic [HOP_W-1:0]     fin_hop;
  logic [CNT_OUT_W-1:0] fin_count;

  logic  accept;
  logic  fin_move;
  kind_t in_kind;
  tok_t  tok_first;
  tok_t  tok_last;

  assign in_kind  = kind_t'(kind);
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  // move the finished result out when the output register is free
  assign fin_move = fin_valid && (!out_valid || out_ready);
  assign tok_last = tok[TABLE_DEPTH];

  // Build the item that enters the row; decide up front what needs no cell
  always_comb begin
    tok_first          = '0;
    tok_first.vld      = 1'b1;
    tok_first.kind     = in_kind;
    tok_first.addr     = address;
    tok_first.len      = route_len;
    tok_first.hop      = route_hop;
    tok_first.status   = ST_OK;
    unique case (in_kind)
      KIND_ADD: begin
        if (route_len > MAX_PREFIX_BITS) begin
          tok_first.status = ST_BAD_LEN;
          tok_first.done   = 1'b1;
        end else if (slots_used >= CNT_W'(TABLE_DEPTH)) begin
          tok_first.status = ST_FULL;
          tok_first.done   = 1'b1;
        end
      end
      KIND_REMOVE: begin
        // a cell that removes the route flips this to ok
        tok_first.status = ST_NOT_FOUND;
      end
      KIND_RESOLVE, KIND_COUNT: begin
        tok_first.status = ST_OK;
      end
      default: begin
        tok_first.status = ST_OK;
      end
    endcase
  end

  // Load the head of the row on an accept; otherwise send an empty slot
  always_ff @(posedge clk) begin
    if (rst || !accept) begin
      tok[0] <= '0;
    end else begin
      tok[0] <= tok_first;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lpmt_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .slots_used (slots_used),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

  // Collect the item at the end of the row and hand it to the output
  always_ff @(posedge clk) begin
    if (tok_last.vld) begin
      unique case (tok_last.kind)
        KIND_RESOLVE: begin
          fin_status <= (tok_last.win_len != '0) ? ST_OK : ST_NOT_FOUND;
          fin_hop    <= tok_last.best_hop;
          fin_count  <= '0;
        end
        KIND_COUNT: begin
          fin_status <= ST_OK;
          fin_hop    <= '0;
          fin_count  <= tok_last.count;
        end
        KIND_ADD, KIND_REMOVE: begin
          fin_status <= tok_last.status;
          fin_hop    <= '0;
          fin_count  <= '0;
        end
        default: begin
          fin_status <= tok_last.status;
          fin_hop    <= '0;
          fin_count  <= '0;
        end
      endcase
    end
    if (fin_move) begin
      status      <= fin_status;
      hop_out     <= fin_hop;
      valid_count <= fin_count;
    end

    if (rst) begin
      busy       <= 1'b0;
      slots_used <= '0;
      fin_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // hold busy until the result has reached the output register
      if (accept) begin
        busy <= 1'b1;
      end else if (fin_move) begin
        busy <= 1'b0;
      end
      if (tok_last.vld && tok_last.appended) begin
        slots_used <= slots_used + 1'b1;
      end
      if (tok_last.vld) begin
        fin_valid <= 1'b1;
      end else if (fin_move) begin
        fin_valid <= 1'b0;
      end
      if (fin_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lpmt_checker.sv -----
// Port-level checks for the longest prefix match table, bound to the top level.
`default_nettype none
module lpmt_checker import lpmt_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [1:0]           status,
  input wire logic [HOP_W-1:0]     hop_out,
  input wire logic [CNT_OUT_W-1:0] valid_count
);

  // one item in flight: no second accept right after the first
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // an error or not-found result carries no hop and no count
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (hop_out == '0) && (valid_count == '0))
    else $error("failed item carries hop or count");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(hop_out) &&
    $stable(valid_count))
    else $error("stalled result changed");

endmodule

bind longest_prefix_match_table_unit lpmt_checker u_lpmt_checker (.*);
`default_nettype wire
